// ----- src/lwhd_pkg.sv -----
// types, codes and rectangle compare functions shared by the widget table
// no dependencies
package lwhd_pkg;

  localparam int MaxNodesDef  = 32;
  localparam int MaxDamageDef = 16;
  localparam int ResultCap    = 32;

  typedef enum logic [2:0] {
    OP_CLR_NODES = 3'd0,
    OP_ADD_NODE  = 3'd1,
    OP_HIT       = 3'd2,
    OP_CLR_DMG   = 3'd3,
    OP_ADD_DMG   = 3'd4,
    OP_REDRAW    = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] LAYER_ANIM    = 2'd1;
  localparam logic [1:0] LAYER_OVERLAY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT,
    S_DMG,
    S_EMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  typedef struct packed {
    rect_t       rect;
    logic [1:0]  layer;
    logic [15:0] tag;
    logic [7:0]  caps;
  } node_t;

  typedef struct packed {
    rect_t      rect;
    logic [1:0] layer;
  } dmg_t;

  typedef struct packed {
    logic       shift;
    logic       clr_hit;
    logic       dmg_chk;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [1:0]         layer;
    logic [15:0]        item_tag;
    logic [7:0]         capability_mask;
    logic               check_capability;
    logic [2:0]         capability_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  node_index;
    logic [15:0] found_tag;
    logic [1:0]  found_layer;
    logic        last;
  } out_t;

  function automatic logic signed [17:0] lo18(logic [15:0] v);
    return $signed({{2{v[15]}}, v});
  endfunction

  function automatic logic signed [17:0] hi18(logic [15:0] v, logic [14:0] w);
    return lo18(v) + $signed({3'b000, w});
  endfunction

  function automatic logic span_meet(logic signed [17:0] a0, logic signed [17:0] a1,
                                     logic signed [17:0] b0, logic signed [17:0] b1);
    return (a0 >= b0 && a0 <= b1) || (a1 >= b0 && a1 <= b1) || (a0 <= b0 && a1 >= b1);
  endfunction

  function automatic logic rect_meet(rect_t a, rect_t b);
    return span_meet(lo18(a.x), hi18(a.x, a.w), lo18(b.x), hi18(b.x, b.w)) &&
           span_meet(lo18(a.y), hi18(a.y, a.h), lo18(b.y), hi18(b.y, b.h));
  endfunction

  function automatic logic point_in(rect_t a, logic [15:0] px, logic [15:0] py);
    return lo18(a.x) <= lo18(px) && lo18(px) <= hi18(a.x, a.w) &&
           lo18(a.y) <= lo18(py) && lo18(py) <= hi18(a.y, a.h);
  endfunction

endpackage

// ----- src/lwhd_node_cell.sv -----
// one node slot of the rotating node chain, with its own damage overlap check
// depends on lwhd_pkg
module lwhd_node_cell (
  input  logic              clk,
  input  lwhd_pkg::cell_ctl_t ctl,
  input  logic              load,
  input  lwhd_pkg::node_t   load_node,
  input  lwhd_pkg::node_t   nbr_node,
  input  logic              nbr_hit,
  input  lwhd_pkg::dmg_t    dmg,
  output lwhd_pkg::node_t   node_q,
  output logic              hit_q
);
  import lwhd_pkg::*;

  node_t node_r;
  logic  hit_r;

  always_ff @(posedge clk) begin
    if (load) begin
      node_r <= load_node;
    end else if (ctl.shift) begin
      node_r <= nbr_node;
    end
  end

  // damage of the same layer that meets the rectangle marks the slot
  always_ff @(posedge clk) begin
    if (ctl.clr_hit) begin
      hit_r <= 1'b0;
    end else if (ctl.shift) begin
      hit_r <= nbr_hit;
    end else if (ctl.dmg_chk && dmg.layer == node_r.layer && rect_meet(node_r.rect, dmg.rect)) begin
      hit_r <= 1'b1;
    end
  end

  assign node_q = node_r;
  assign hit_q  = hit_r;

endmodule

// ----- src/lwhd_dmg_cell.sv -----
// one damage slot of the rotating damage chain
// depends on lwhd_pkg
module lwhd_dmg_cell (
  input  logic           clk,
  input  logic           shift,
  input  logic           load,
  input  lwhd_pkg::dmg_t load_dmg,
  input  lwhd_pkg::dmg_t nbr_dmg,
  output lwhd_pkg::dmg_t dmg_q
);
  import lwhd_pkg::*;

  dmg_t dmg_r;

  always_ff @(posedge clk) begin
    if (load) begin
      dmg_r <= load_dmg;
    end else if (shift) begin
      dmg_r <= nbr_dmg;
    end
  end

  assign dmg_q = dmg_r;

endmodule

// ----- src/layered_widget_hit_and_damage_table.sv -----
// top level of the layered widget hit and damage table
// depends on lwhd_pkg, lwhd_node_cell, lwhd_dmg_cell
//
//   channel   ports                    transfer
//   input     start, busy, in_item     start high while busy low
//   result    out_valid, out_item      one cycle per result, no back-pressure
//
// clears, adds and unknown codes: result in the cycle after the transaction, busy stays low
// hit query: busy during the scan, one node compared per cycle at the chain head
// redraw: busy while each damage slot in turn is broadcast
//   to all node cells, then the node chain is rotated once per layer group
// reset is synchronous and clears the counts and the sequencer; stores hold garbage
// the receiver cannot stall, results are simply presented for one cycle
module layered_widget_hit_and_damage_table #(
  parameter int MAX_NODES  = lwhd_pkg::MaxNodesDef,
  parameter int MAX_DAMAGE = lwhd_pkg::MaxDamageDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lwhd_pkg::in_t  in_item,
  output logic           out_valid,
  output lwhd_pkg::out_t out_item
);
  import lwhd_pkg::*;

  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int DCW = $clog2(MAX_DAMAGE + 1);

  // chains of cells
  node_t                 cell_q [MAX_NODES];
  logic                  cell_hit [MAX_NODES];
  logic [MAX_NODES-1:0]  cell_load;
  node_t                 new_node;
  cell_ctl_t             ctl;
  dmg_t                  dcell_q [MAX_DAMAGE];
  logic [MAX_DAMAGE-1:0] dcell_load;
  dmg_t                  new_dmg;
  logic                  dshift;

  // sequencer and counters
  state_t         state_r, state_nxt;
  logic [NCW-1:0] ncnt_r, ncnt_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [NCW-1:0] i_r, i_nxt;
  logic [DCW-1:0] j_r, j_nxt;
  logic [1:0]     g_r, g_nxt;
  logic [5:0]     n_r, n_nxt;

  // query and pending result
  logic [15:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic        qchk_r, qchk_nxt;
  logic [2:0]  qbit_r, qbit_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [4:0]  pend_idx_r, pend_idx_nxt;
  logic [15:0] pend_tag_r, pend_tag_nxt;
  logic [1:0]  pend_lay_r, pend_lay_nxt;

  logic  out_valid_r, out_valid_nxt;
  out_t  out_r, out_nxt;

  op_t   op;
  logic  acc;
  node_t head;
  logic  hit_cand, emit_match;
  logic  i_end, j_end;

  assign busy  = (state_r != S_IDLE);
  assign acc   = start && !busy;
  assign op    = op_t'(in_item.operation);
  assign head  = cell_q[0];
  assign i_end = (i_r == NCW'(MAX_NODES - 1));
  assign j_end = (j_r == DCW'(MAX_DAMAGE - 1));

  always_comb begin
    new_node.rect  = '{x: in_item.pos_x, y: in_item.pos_y,
                       w: in_item.width, h: in_item.height};
    new_node.layer = in_item.layer;
    new_node.tag   = in_item.item_tag;
    new_node.caps  = in_item.capability_mask;
    new_dmg.rect   = new_node.rect;
    new_dmg.layer  = in_item.layer;
  end

  genvar k;
  generate
    for (k = 0; k < MAX_NODES; k++) begin : g_node
      lwhd_node_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .load      (cell_load[k]),
        .load_node (new_node),
        .nbr_node  (cell_q[(k + 1) % MAX_NODES]),
        .nbr_hit   (cell_hit[(k + 1) % MAX_NODES]),
        .dmg       (dcell_q[0]),
        .node_q    (cell_q[k]),
        .hit_q     (cell_hit[k])
      );
    end
    for (k = 0; k < MAX_DAMAGE; k++) begin : g_dmg
      lwhd_dmg_cell u_dcell (
        .clk      (clk),
        .shift    (dshift),
        .load     (dcell_load[k]),
        .load_dmg (new_dmg),
        .nbr_dmg  (dcell_q[(k + 1) % MAX_DAMAGE]),
        .dmg_q    (dcell_q[k])
      );
    end
  endgenerate

  // hit candidate at the chain head: layer 1 skipped, overlay lock, capability filter
  assign hit_cand = (i_r < ncnt_r) && head.layer != LAYER_ANIM &&
                    !(pend_v_r && pend_lay_r == LAYER_OVERLAY && head.layer != LAYER_OVERLAY) &&
                    (!qchk_r || head.caps[qbit_r]) &&
                    point_in(head.rect, qx_r, qy_r);

  assign emit_match = (i_r < ncnt_r) && head.layer == g_r && cell_hit[0] &&
                      (n_r < 6'(ResultCap));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && op == OP_HIT) state_nxt = S_HIT;
        else if (acc && op == OP_REDRAW) state_nxt = S_DMG;
      end
      S_HIT:  if (i_end) state_nxt = S_FIN;
      S_DMG:  if (j_end) state_nxt = S_EMIT;
      S_EMIT: if (i_end && g_r == LAYER_OVERLAY) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ncnt_nxt      = ncnt_r;
    dcnt_nxt      = dcnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    g_nxt         = g_r;
    n_nxt         = n_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qchk_nxt      = qchk_r;
    qbit_nxt      = qbit_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    pend_tag_nxt  = pend_tag_r;
    pend_lay_nxt  = pend_lay_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctl           = '0;
    cell_load     = '0;
    dcell_load    = '0;
    dshift        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_OK, node_index: 5'd0, found_tag: 16'd0,
                            found_layer: 2'd0, last: 1'b1};
          unique case (op)
            OP_CLR_NODES: ncnt_nxt = '0;
            OP_ADD_NODE: begin
              if (ncnt_r < NCW'(MAX_NODES)) begin
                for (int c = 0; c < MAX_NODES; c++) begin
                  cell_load[c] = (ncnt_r == NCW'(c));
                end
                ncnt_nxt            = ncnt_r + 1'b1;
                out_nxt.node_index  = 5'(ncnt_r);
                out_nxt.found_tag   = in_item.item_tag;
                out_nxt.found_layer = in_item.layer;
              end else begin
                out_nxt.status = ST_FULL;
              end
            end
            OP_HIT: begin
              out_valid_nxt = 1'b0;
              qx_nxt        = in_item.pos_x;
              qy_nxt        = in_item.pos_y;
              qchk_nxt      = in_item.check_capability;
              qbit_nxt      = in_item.capability_index;
              i_nxt         = '0;
              pend_v_nxt    = 1'b0;
            end
            OP_CLR_DMG: dcnt_nxt = '0;
            OP_ADD_DMG: begin
              if (dcnt_r < DCW'(MAX_DAMAGE)) begin
                for (int c = 0; c < MAX_DAMAGE; c++) begin
                  dcell_load[c] = (dcnt_r == DCW'(c));
                end
                dcnt_nxt            = dcnt_r + 1'b1;
                out_nxt.node_index  = 5'(dcnt_r);
                out_nxt.found_layer = in_item.layer;
              end else begin
                out_nxt.status = ST_FULL;
              end
            end
            OP_REDRAW: begin
              out_valid_nxt = 1'b0;
              ctl.clr_hit   = 1'b1;
              i_nxt         = '0;
              j_nxt         = '0;
              g_nxt         = '0;
              n_nxt         = '0;
              pend_v_nxt    = 1'b0;
            end
            default: out_nxt.status = ST_NONE;
          endcase
        end
      end
      S_HIT: begin
        ctl.shift = 1'b1;
        i_nxt     = i_r + 1'b1;
        if (hit_cand) begin
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = 5'(i_r);
          pend_tag_nxt = head.tag;
          pend_lay_nxt = head.layer;
        end
      end
      S_DMG: begin
        // every node cell checks the damage slot now at the head
        dshift      = 1'b1;
        ctl.dmg_chk = (j_r < dcnt_r);
        j_nxt       = j_r + 1'b1;
      end
      S_EMIT: begin
        ctl.shift = 1'b1;
        i_nxt     = i_end ? '0 : i_r + 1'b1;
        if (i_end) g_nxt = g_r + 1'b1;
        if (emit_match) begin
          // one result held back so that the final one can carry last
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_OK, node_index: pend_idx_r, found_tag: pend_tag_r,
                              found_layer: pend_lay_r, last: 1'b0};
          end
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = 5'(i_r);
          pend_tag_nxt = head.tag;
          pend_lay_nxt = head.layer;
          n_nxt        = n_r + 1'b1;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt = '{status: ST_OK, node_index: pend_idx_r, found_tag: pend_tag_r,
                      found_layer: pend_lay_r, last: 1'b1};
        end else begin
          out_nxt = '{status: ST_NONE, node_index: 5'd0, found_tag: 16'd0,
                      found_layer: 2'd0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ncnt_r      <= '0;
      dcnt_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ncnt_r      <= ncnt_nxt;
      dcnt_r      <= dcnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    g_r        <= g_nxt;
    n_r        <= n_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    qchk_r     <= qchk_nxt;
    qbit_r     <= qbit_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
    pend_lay_r <= pend_lay_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  a_ncnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ncnt_r <= NCW'(MAX_NODES) && dcnt_r <= DCW'(MAX_DAMAGE))
    else $error("table count beyond capacity");

  a_simple_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.operation != OP_HIT && in_item.operation != OP_REDRAW
    |=> out_valid && out_item.last)
    else $error("missing result after simple transaction");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final result outside a redraw");

  a_query_silent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HIT || state_r == S_DMG |-> !out_valid_nxt)
    else $error("result raised during hit scan or damage sweep");

endmodule

// ----- test/lwhd_checker.sv -----
// checker for the widget table: watches both channels, keeps its own copy of the table
// and compares every result; depends on lwhd_pkg
`timescale 1ns / 1ps
module lwhd_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  lwhd_pkg::in_t  in_item,
  input  logic           out_valid,
  input  lwhd_pkg::out_t out_item,
  output int             fail_count,
  output int             pending_count,
  output int             result_count
);
  import lwhd_pkg::*;

  localparam int NodeSlots = 32;
  localparam int DmgSlots  = 16;

  in_t  node_store [NodeSlots];
  in_t  dmg_store  [DmgSlots];
  int   nodes_held;
  int   dmgs_held;
  out_t expected_results [$];

  function automatic logic signed [17:0] ext18(logic [15:0] v);
    return $signed({{2{v[15]}}, v});
  endfunction

  function automatic logic signed [17:0] end18(logic [15:0] v, logic [14:0] w);
    return ext18(v) + $signed({3'b000, w});
  endfunction

  function automatic logic spans_touch(logic signed [17:0] a0, logic signed [17:0] a1,
                                       logic signed [17:0] b0, logic signed [17:0] b1);
    return (a0 >= b0 && a0 <= b1) || (a1 >= b0 && a1 <= b1) || (a0 <= b0 && a1 >= b1);
  endfunction

  function automatic out_t mk_res(logic [1:0] st, int idx, logic [15:0] tag,
                                  logic [1:0] lay, logic lst);
    out_t r;
    r.status      = st;
    r.node_index  = idx[4:0];
    r.found_tag   = tag;
    r.found_layer = lay;
    r.last        = lst;
    return r;
  endfunction

  task automatic predict_results(in_t it);
    logic       found;
    int         sel;
    logic [1:0] sel_layer;
    logic       touched;
    int         n;
    in_t        e;
    in_t        d;
    found = 1'b0;
    sel = 0;
    sel_layer = 2'd0;
    n = 0;
    case (it.operation)
      OP_CLR_NODES: begin
        nodes_held = 0;
        expected_results.push_back(mk_res(ST_OK, 0, 16'd0, 2'd0, 1'b1));
      end
      OP_ADD_NODE: begin
        if (nodes_held >= NodeSlots) begin
          expected_results.push_back(mk_res(ST_FULL, 0, 16'd0, 2'd0, 1'b1));
        end else begin
          node_store[nodes_held] = it;
          expected_results.push_back(mk_res(ST_OK, nodes_held, it.item_tag, it.layer, 1'b1));
          nodes_held++;
        end
      end
      OP_HIT: begin
        for (int i = 0; i < nodes_held; i++) begin
          e = node_store[i];
          if (e.layer == LAYER_ANIM) continue;
          if (sel_layer == LAYER_OVERLAY && e.layer != LAYER_OVERLAY) continue;
          if (it.check_capability && !e.capability_mask[it.capability_index]) continue;
          if (ext18(e.pos_x) <= ext18(it.pos_x) && ext18(it.pos_x) <= end18(e.pos_x, e.width) &&
              ext18(e.pos_y) <= ext18(it.pos_y) && ext18(it.pos_y) <= end18(e.pos_y, e.height))
          begin
            found = 1'b1;
            sel = i;
            sel_layer = e.layer;
          end
        end
        if (found) begin
          expected_results.push_back(mk_res(ST_OK, sel, node_store[sel].item_tag,
                                             node_store[sel].layer, 1'b1));
        end else begin
          expected_results.push_back(mk_res(ST_NONE, 0, 16'd0, 2'd0, 1'b1));
        end
      end
      OP_CLR_DMG: begin
        dmgs_held = 0;
        expected_results.push_back(mk_res(ST_OK, 0, 16'd0, 2'd0, 1'b1));
      end
      OP_ADD_DMG: begin
        if (dmgs_held >= DmgSlots) begin
          expected_results.push_back(mk_res(ST_FULL, 0, 16'd0, 2'd0, 1'b1));
        end else begin
          dmg_store[dmgs_held] = it;
          expected_results.push_back(mk_res(ST_OK, dmgs_held, 16'd0, it.layer, 1'b1));
          dmgs_held++;
        end
      end
      OP_REDRAW: begin
        // layer groups 0, 1, 2 in turn, each in table order; layer 3 never emitted
        for (int g = 0; g < 3; g++) begin
          for (int i = 0; i < nodes_held; i++) begin
            e = node_store[i];
            if (e.layer != g[1:0]) continue;
            touched = 1'b0;
            for (int j = 0; j < dmgs_held; j++) begin
              d = dmg_store[j];
              if (d.layer == e.layer &&
                  spans_touch(ext18(e.pos_x), end18(e.pos_x, e.width),
                              ext18(d.pos_x), end18(d.pos_x, d.width)) &&
                  spans_touch(ext18(e.pos_y), end18(e.pos_y, e.height),
                              ext18(d.pos_y), end18(d.pos_y, d.height)))
                touched = 1'b1;
            end
            if (touched && n < ResultCap) begin
              expected_results.push_back(mk_res(ST_OK, i, e.item_tag, e.layer, 1'b0));
              n++;
            end
          end
        end
        if (n == 0) begin
          expected_results.push_back(mk_res(ST_NONE, 0, 16'd0, 2'd0, 1'b1));
        end else begin
          expected_results[$].last = 1'b1;
        end
      end
      default: begin
        expected_results.push_back(mk_res(ST_NONE, 0, 16'd0, 2'd0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      nodes_held = 0;
      dmgs_held = 0;
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_item) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_results(in_item);
    end
    pending_count <= expected_results.size();
  end

endmodule

// ----- test/tb_top.sv -----
// top of the widget table testbench: clock, reset, stimulus, watchdog and verdict
// depends on lwhd_pkg, lwhd_checker and the block itself
`timescale 1ns / 1ps
module tb_top;
  import lwhd_pkg::*;

  localparam int WatchLimit = 4000;   // longer than the slowest busy stretch
  localparam int ItemGoal   = 300;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  in_t   in_item = '0;
  logic  busy;
  logic  out_valid;
  out_t  out_item;
  int    fail_count;
  int    pending_count;
  int    result_count;
  int    idle_cycles = 0;
  int    sent = 0;
  logic  quiet = 1'b0;       // no idling in the closing stretch

  layered_widget_hit_and_damage_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  lwhd_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .result_count (result_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: any cycle without a transaction on either side counts up
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic in_t mk_item(logic [2:0] op, logic [15:0] x, logic [15:0] y,
                                  logic [14:0] w, logic [14:0] h, logic [1:0] lay,
                                  logic [15:0] tag, logic [7:0] caps, logic chk_en,
                                  logic [2:0] cidx);
    in_t it;
    it.operation        = op;
    it.pos_x            = x;
    it.pos_y            = y;
    it.width            = w;
    it.height           = h;
    it.layer            = lay;
    it.item_tag         = tag;
    it.capability_mask  = caps;
    it.check_capability = chk_en;
    it.capability_index = cidx;
    return it;
  endfunction

  // random content; coordinates mostly in a small window so rectangles meet often
  function automatic in_t rnd_item(logic [2:0] op);
    in_t it;
    it = mk_item(op, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                 2'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
    if ($urandom_range(0, 7) != 0) begin
      it.pos_x  = 16'($signed($urandom_range(0, 256)) - 128);
      it.pos_y  = 16'($signed($urandom_range(0, 256)) - 128);
      it.width  = 15'($urandom_range(0, 96));
      it.height = 15'($urandom_range(0, 96));
    end
    return it;
  endfunction

  // hold the transaction until the block takes it, then maybe leave a gap
  task automatic send(in_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    int n_nodes;
    int n_dmg;
    int n_query;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queries, field extremes, every layer, filter, unknown codes
    send(mk_item(OP_HIT, 16'h0000, 16'h0000, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_REDRAW, '0, '0, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_ADD_NODE, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 2'd0, 16'hffff,
                 8'hff, 1'b1, 3'd7));
    send(mk_item(OP_ADD_NODE, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 2'd3, 16'h0000,
                 8'h00, 1'b0, 3'd0));
    send(mk_item(OP_ADD_NODE, 16'h0000, 16'h0000, 15'd16, 15'd16, 2'd1, 16'h1111,
                 8'h01, 1'b0, 3'd0));
    send(mk_item(OP_ADD_NODE, 16'h0000, 16'h0000, 15'd16, 15'd16, 2'd2, 16'h2222,
                 8'h80, 1'b0, 3'd0));
    send(mk_item(OP_ADD_NODE, 16'h0000, 16'h0000, 15'd0, 15'd0, 2'd0, 16'h3333,
                 8'h80, 1'b0, 3'd0));
    // point on a closed corner; overlay chosen earlier must stick over layer 0
    send(mk_item(OP_HIT, 16'h0000, 16'h0000, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_HIT, 16'd16, 16'd16, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_HIT, 16'h0000, 16'h0000, '0, '0, 2'd0, '0, '0, 1'b1, 3'd7));
    send(mk_item(OP_HIT, 16'h0000, 16'h0000, '0, '0, 2'd0, '0, '0, 1'b1, 3'd0));
    send(mk_item(OP_HIT, 16'h7fff, 16'h7fff, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_HIT, 16'h8000, 16'h8000, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_ADD_DMG, 16'd16, 16'd16, 15'd0, 15'd0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_ADD_DMG, 16'h0000, 16'h0000, 15'd4, 15'd4, 2'd1, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_ADD_DMG, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 2'd2, '0, '0,
                 1'b0, 3'd0));
    send(mk_item(OP_ADD_DMG, 16'h7fff, 16'h7fff, 15'd0, 15'd0, 2'd3, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_REDRAW, '0, '0, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(3'd6, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff, 2'd3, 16'hffff, 8'hff,
                 1'b1, 3'd7));
    send(mk_item(3'd7, '0, '0, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_CLR_DMG, '0, '0, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_REDRAW, '0, '0, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));
    send(mk_item(OP_CLR_NODES, '0, '0, '0, '0, 2'd0, '0, '0, 1'b0, 3'd0));

    // random: rebuild the table, fill damage, then query; sometimes overfill
    while (sent < ItemGoal) begin
      if (sent > ItemGoal - 40) quiet = 1'b1;
      if ($urandom_range(0, 1) == 0) send(rnd_item(OP_CLR_NODES));
      if ($urandom_range(0, 1) == 0) send(rnd_item(OP_CLR_DMG));
      n_nodes = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 10);
      n_dmg   = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
      n_query = $urandom_range(2, 8);
      repeat (n_nodes) send(rnd_item(OP_ADD_NODE));
      repeat (n_dmg) send(rnd_item(OP_ADD_DMG));
      repeat (n_query) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send(rnd_item(OP_HIT));
          5, 6, 7:       send(rnd_item(OP_REDRAW));
          8:             send(rnd_item(3'($urandom_range(6, 7))));
          default:       send(rnd_item(3'($urandom)));
        endcase
      end
    end
    start <= 1'b0;

    // drain, then let any trailing busy stretch finish
    while (pending_count != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("sent %0d transactions, observed %0d results", sent, result_count);
    $display("covered adds past full, hits with filter and layers, redraw in groups");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
